FILE: sv/median_of_positive_values_top_defines.svh
// Assertion macros for the median block checker.
// Used by mopv_checker; no other dependencies.
`ifndef MEDIAN_OF_POSITIVE_VALUES_TOP_DEFINES_SVH
`define MEDIAN_OF_POSITIVE_VALUES_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define MOPV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define MOPV_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/mopv_pkg.sv
// Shared constants and controller/datapath interface types for the median block.
// No dependencies.
package mopv_pkg;

    localparam int MAX_ITEMS_DEF   = 256;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int THR_WIDTH       = 32;
    localparam int CNT_OUT_WIDTH   = 9;
    localparam int APB_AW          = 3;
    localparam int APB_DW          = 32;
    localparam int CMP_WIDTH       = 64;

    // register index = paddr[2]
    localparam logic REG_IDX_THRESH = 1'b0;

    typedef enum logic [1:0] {
        RD_POS_M1 = 2'd0,
        RD_POS_M2 = 2'd1,
        RD_MED_LO = 2'd2,
        RD_MED_HI = 2'd3
    } t_rd_sel;

    typedef enum logic {
        WR_SHIFT = 1'b0,
        WR_KEY   = 1'b1
    } t_wr_sel;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    wr_en;
        t_wr_sel wr_sel;
        logic    pos_dec;
        logic    cnt_inc;
        logic    ovf_set;
        logic    lat_lo;
        logic    lat_hi;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        logic keep;
        logic full;
        logic pos_zero;
        logic pos_one;
        logic rd_gt_key;
        logic last;
        logic out_free;
    } t_status;

endpackage

FILE: sv/mopv_ctrl.sv
// Sequencer for the median block: insertion, median fetch and result hand-off.
// Depends on mopv_pkg.
module mopv_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  mopv_pkg::t_status i_status,
    output logic              o_in_ready,
    output mopv_pkg::t_cmd    o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE   = 8'b0000_0001,
        S_CHECK  = 8'b0000_0010,
        S_CMP    = 8'b0000_0100,
        S_PUT    = 8'b0000_1000,
        S_FINISH = 8'b0001_0000,
        S_MLO    = 8'b0010_0000,
        S_MHI    = 8'b0100_0000,
        S_MOUT   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (i_status.keep && i_status.full) begin
                    o_cmd.ovf_set = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.keep && i_status.pos_zero) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = mopv_pkg::WR_KEY;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_FINISH;
                end else if (i_status.keep) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mopv_pkg::RD_POS_M1;
                    n_state      = S_CMP;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_CMP: begin
                // move the larger entry up one slot, fetch the next one down
                if (i_status.rd_gt_key) begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = mopv_pkg::WR_SHIFT;
                    o_cmd.pos_dec = 1'b1;
                    if (i_status.pos_one) begin
                        n_state = S_PUT;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = mopv_pkg::RD_POS_M2;
                    end
                end else begin
                    o_cmd.wr_en   = 1'b1;
                    o_cmd.wr_sel  = mopv_pkg::WR_KEY;
                    o_cmd.cnt_inc = 1'b1;
                    n_state       = S_FINISH;
                end
            end
            S_PUT: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = mopv_pkg::WR_KEY;
                o_cmd.cnt_inc = 1'b1;
                n_state       = S_FINISH;
            end
            S_FINISH: begin
                if (i_status.last) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = mopv_pkg::RD_MED_LO;
                    n_state      = S_MLO;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_MLO: begin
                o_cmd.lat_lo = 1'b1;
                o_cmd.rd_en  = 1'b1;
                o_cmd.rd_sel = mopv_pkg::RD_MED_HI;
                n_state      = S_MHI;
            end
            S_MHI: begin
                o_cmd.lat_hi = 1'b1;
                n_state      = S_MOUT;
            end
            S_MOUT: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/mopv_datapath.sv
// Datapath: sorted value memory, count/overflow, median arithmetic, output register.
// Depends on mopv_pkg; driven by mopv_ctrl.
module mopv_datapath #(
    parameter int MAX_ITEMS   = mopv_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mopv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  mopv_pkg::t_cmd                       i_cmd,
    input  logic signed [VALUE_WIDTH-1:0]        i_sample_value,
    input  logic                                 i_is_last,
    input  logic signed [mopv_pkg::THR_WIDTH-1:0] i_threshold,
    input  logic                                 i_out_ready,
    output mopv_pkg::t_status                    o_status,
    output logic                                 o_out_valid,
    output logic signed [VALUE_WIDTH-1:0]        o_median_value,
    output logic [mopv_pkg::CNT_OUT_WIDTH-1:0]   o_kept_count,
    output logic                                 o_overflowed
);

    localparam int AW   = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNTW = $clog2(MAX_ITEMS + 1);
    localparam int CW   = mopv_pkg::CMP_WIDTH;

    logic [VALUE_WIDTH-1:0] r_mem [MAX_ITEMS];

    logic signed [VALUE_WIDTH-1:0] r_key, r_rd_data, r_lo, r_hi;
    logic                          r_keep, r_last, r_ovf;
    logic [CNTW-1:0]               r_count, r_pos;

    logic                          r_out_valid;
    logic signed [VALUE_WIDTH-1:0] r_out_med;
    logic [CNTW-1:0]               r_out_cnt;
    logic                          r_out_ovf;

    logic [AW-1:0]               rd_addr;
    logic [VALUE_WIDTH-1:0]      wr_data;
    logic [CNTW-1:0]             half;
    logic signed [CW-1:0]        samp_ext, thr_ext;
    logic signed [VALUE_WIDTH:0] pair_sum;
    logic signed [VALUE_WIDTH-1:0] med;
    logic                        out_free;

    assign samp_ext = CW'(i_sample_value);
    assign thr_ext  = CW'(i_threshold);
    assign half     = r_count >> 1;

    always_comb begin
        case (i_cmd.rd_sel)
            mopv_pkg::RD_POS_M1: rd_addr = AW'(r_pos - CNTW'(1));
            mopv_pkg::RD_POS_M2: rd_addr = AW'(r_pos - CNTW'(2));
            mopv_pkg::RD_MED_LO: rd_addr = r_count[0] ? AW'(half) : AW'(half - CNTW'(1));
            default:             rd_addr = AW'(half);
        endcase
    end

    assign wr_data = (i_cmd.wr_sel == mopv_pkg::WR_KEY) ? r_key : r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[AW'(r_pos)] <= wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key  <= i_sample_value;
            r_keep <= (samp_ext > thr_ext);
        end
        if (i_cmd.lat_lo) begin
            r_lo <= r_rd_data;
        end
        if (i_cmd.lat_hi) begin
            r_hi <= r_rd_data;
        end
        if (i_cmd.out_load) begin
            r_out_med <= med;
            r_out_cnt <= r_count;
            r_out_ovf <= r_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_pos       <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_pos  <= r_count;
                r_last <= i_is_last;
            end else if (i_cmd.pos_dec) begin
                r_pos <= r_pos - CNTW'(1);
            end
            if (i_cmd.out_load) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
            end else begin
                if (i_cmd.cnt_inc) begin
                    r_count <= r_count + CNTW'(1);
                end
                if (i_cmd.ovf_set) begin
                    r_ovf <= 1'b1;
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // floor of the mean of the two middle values
    assign pair_sum = (VALUE_WIDTH + 1)'(r_lo) + (VALUE_WIDTH + 1)'(r_hi);

    always_comb begin
        if (r_count < CNTW'(2)) begin
            med = '0;
        end else if (r_count[0]) begin
            med = r_lo;
        end else begin
            med = pair_sum[VALUE_WIDTH:1];
        end
    end

    assign out_free = !r_out_valid || i_out_ready;

    assign o_status.keep      = r_keep;
    assign o_status.full      = (r_count == CNTW'(MAX_ITEMS));
    assign o_status.pos_zero  = (r_pos == '0);
    assign o_status.pos_one   = (r_pos == CNTW'(1));
    assign o_status.rd_gt_key = (r_rd_data > r_key);
    assign o_status.last      = r_last;
    assign o_status.out_free  = out_free;

    assign o_out_valid    = r_out_valid;
    assign o_median_value = r_out_med;
    assign o_kept_count   = mopv_pkg::CNT_OUT_WIDTH'(r_out_cnt);
    assign o_overflowed   = r_out_ovf;

endmodule

FILE: sv/median_of_positive_values_top.sv
// Median of the values above a programmable threshold, one vector per frame.
// Each accepted transaction carries one element; a kept element is placed in a
// sorted memory by shifting larger entries up one slot per cycle. An element
// that is dropped, or that arrives while the store is empty or full, moves no
// entries; otherwise each stored entry larger than it (at most MAX_ITEMS - 1)
// is moved up in turn through the single-port sorted memory. After the last
// element the block reads the middle entries, lower then upper, and loads the
// output register, waiting for that register to free up. The register may hold
// a result while the next vector is already streaming in. The threshold register
// sits at byte address 0.
// Depends on mopv_pkg, mopv_ctrl and mopv_datapath.
module median_of_positive_values_top #(
    parameter int MAX_ITEMS   = mopv_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mopv_pkg::VALUE_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic signed [VALUE_WIDTH-1:0]        i_sample_value,
    input  logic                                 i_is_last,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [VALUE_WIDTH-1:0]        o_median_value,
    output logic [mopv_pkg::CNT_OUT_WIDTH-1:0]   o_kept_count,
    output logic                                 o_overflowed,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mopv_pkg::APB_AW-1:0]          paddr,
    input  logic [mopv_pkg::APB_DW-1:0]          pwdata,
    output logic [mopv_pkg::APB_DW-1:0]          prdata,
    output logic                                 pready
);

    logic signed [mopv_pkg::THR_WIDTH-1:0] r_threshold;
    mopv_pkg::t_cmd    cmd;
    mopv_pkg::t_status status;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= '0;
        end else if (psel && penable && pwrite && pready
                     && paddr[2] == mopv_pkg::REG_IDX_THRESH) begin
            r_threshold <= pwdata;
        end
    end

    assign prdata = (paddr[2] == mopv_pkg::REG_IDX_THRESH) ? r_threshold : '0;

    mopv_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_in_ready (o_in_ready),
        .o_cmd      (cmd)
    );

    mopv_datapath #(
        .MAX_ITEMS   (MAX_ITEMS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_sample_value (i_sample_value),
        .i_is_last      (i_is_last),
        .i_threshold    (r_threshold),
        .i_out_ready    (i_out_ready),
        .o_status       (status),
        .o_out_valid    (o_out_valid),
        .o_median_value (o_median_value),
        .o_kept_count   (o_kept_count),
        .o_overflowed   (o_overflowed)
    );

endmodule

FILE: sv/mopv_checker.sv
// Port-level checks for the median block, bound to the top level.
// Depends on mopv_pkg and median_of_positive_values_top_defines.svh.
`include "median_of_positive_values_top_defines.svh"

module mopv_checker #(
    parameter int MAX_ITEMS   = mopv_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_WIDTH = mopv_pkg::VALUE_WIDTH_DEF
) (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               o_out_valid,
    input logic                               i_out_ready,
    input logic [VALUE_WIDTH-1:0]             o_median_value,
    input logic [mopv_pkg::CNT_OUT_WIDTH-1:0] o_kept_count,
    input logic                               o_overflowed
);

    localparam logic SMALL_CAP = (MAX_ITEMS < 512);

    `MOPV_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid, "result dropped before transaction")

    `MOPV_ASSERT_IMP(a_ovf_full, i_clk, i_rst_n, o_out_valid && o_overflowed, o_kept_count == mopv_pkg::CNT_OUT_WIDTH'(MAX_ITEMS), "overflow flagged with store not full")

    `MOPV_ASSERT_IMP(a_small_zero, i_clk, i_rst_n, SMALL_CAP && o_out_valid && o_kept_count < 9'd2, o_median_value == '0, "median nonzero with fewer than two kept")

endmodule

bind median_of_positive_values_top mopv_checker #(
    .MAX_ITEMS   (MAX_ITEMS),
    .VALUE_WIDTH (VALUE_WIDTH)
) u_mopv_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_median_value (o_median_value),
    .o_kept_count   (o_kept_count),
    .o_overflowed   (o_overflowed)
);

FILE: tb/median_checker.sv
// Checker for median_of_positive_values_top: watches the APB port and both streams,
// predicts each vector's result and compares it. Depends on mopv_pkg.
module median_checker (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   in_valid,
    input  logic                                   in_ready,
    input  logic signed [mopv_pkg::VALUE_WIDTH_DEF-1:0] sample_value,
    input  logic                                   is_last,
    input  logic                                   out_valid,
    input  logic                                   out_ready,
    input  logic signed [mopv_pkg::VALUE_WIDTH_DEF-1:0] median_value,
    input  logic [mopv_pkg::CNT_OUT_WIDTH-1:0]     kept_count,
    input  logic                                   overflowed,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic                                   pready,
    input  logic [mopv_pkg::APB_AW-1:0]            paddr,
    input  logic [mopv_pkg::APB_DW-1:0]            pwdata,
    output int                                     fail_count,
    output int                                     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW    = mopv_pkg::VALUE_WIDTH_DEF;
    localparam int CW    = mopv_pkg::CNT_OUT_WIDTH;
    localparam int DEPTH = mopv_pkg::MAX_ITEMS_DEF;

    typedef struct {
        logic signed [VW-1:0] median;
        logic [CW-1:0]        count;
        logic                 ovf;
    } t_median_result;

    t_median_result       medians_due[$];
    logic signed [31:0]   threshold;
    longint               sorted_kept[$];
    logic                 dropped;

    assign pending = medians_due.size();

    task automatic report(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Insert keeping ascending order; ties go after equal entries.
    task automatic take_sample(input logic signed [VW-1:0] v);
        int pos;
        pos = sorted_kept.size();
        if (v > threshold) begin
            if (sorted_kept.size() < DEPTH) begin
                while (pos > 0 && sorted_kept[pos-1] > longint'(v))
                    pos--;
                sorted_kept.insert(pos, longint'(v));
            end else begin
                dropped = 1'b1;
            end
        end
    endtask

    function automatic t_median_result close_vector();
        t_median_result r;
        int n;
        n = sorted_kept.size();
        if (n <= 1)
            r.median = '0;
        else if (n % 2 == 1)
            r.median = VW'(sorted_kept[n/2]);
        else
            r.median = VW'((sorted_kept[n/2-1] + sorted_kept[n/2]) >>> 1);
        r.count = CW'(n);
        r.ovf = dropped;
        return r;
    endfunction

    initial begin
        fail_count = 0;
        threshold = '0;
        dropped = 1'b0;
    end

    always @(posedge i_clk) begin
        t_median_result want;
        if (i_rst_n) begin
            if (psel && penable && pwrite && pready && paddr[2] == mopv_pkg::REG_IDX_THRESH)
                threshold = pwdata;
            if (out_valid && out_ready) begin
                if (medians_due.size() == 0) begin
                    report("unexpected result, median", median_value, 0);
                end else begin
                    want = medians_due.pop_front();
                    if (median_value !== want.median)
                        report("median_value", median_value, want.median);
                    if (kept_count !== want.count)
                        report("kept_count", kept_count, want.count);
                    if (overflowed !== want.ovf)
                        report("overflowed", overflowed, want.ovf);
                end
            end
            if (in_valid && in_ready) begin
                take_sample(sample_value);
                if (is_last) begin
                    medians_due = {medians_due, close_vector()};
                    sorted_kept.delete();
                    dropped = 1'b0;
                end
            end
        end
    end
endmodule

FILE: tb/median_of_positive_values_top_test.sv
// Stimulus and verdict for median_of_positive_values_top: directed and random vectors,
// APB threshold writes between phases. Depends on mopv_pkg and median_checker.
module median_of_positive_values_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW = mopv_pkg::VALUE_WIDTH_DEF;
    localparam logic [mopv_pkg::APB_AW-1:0] ADDR_THRESHOLD = {mopv_pkg::REG_IDX_THRESH, 2'b00};
    localparam logic [mopv_pkg::APB_AW-1:0] ADDR_UNMAPPED  = {~mopv_pkg::REG_IDX_THRESH, 2'b00};
    localparam int SETTLE_CYCLES = 600;
    localparam longint CYCLE_LIMIT = 3_000_000;
    localparam longint VMAX = 64'sd2147483647;
    localparam longint VMIN = -64'sd2147483648;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    logic signed [VW-1:0]  i_sample_value = '0;
    logic                  i_is_last = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    logic signed [VW-1:0]  o_median_value;
    logic [mopv_pkg::CNT_OUT_WIDTH-1:0] o_kept_count;
    logic                  o_overflowed;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [mopv_pkg::APB_AW-1:0] paddr = '0;
    logic [mopv_pkg::APB_DW-1:0] pwdata = '0;
    logic [mopv_pkg::APB_DW-1:0] prdata;
    logic                  pready;

    int     fail_count;
    int     pending;
    longint cycles = 0;
    longint thr_now = 0;
    bit     no_gaps = 1'b0;
    bit     hold_sink = 1'b0;

    always #5 i_clk = ~i_clk;

    median_of_positive_values_top dut (.*);

    median_checker u_checker (
        .i_clk, .i_rst_n,
        .in_valid(i_in_valid), .in_ready(o_in_ready),
        .sample_value(i_sample_value), .is_last(i_is_last),
        .out_valid(o_out_valid), .out_ready(i_out_ready),
        .median_value(o_median_value), .kept_count(o_kept_count),
        .overflowed(o_overflowed),
        .psel, .penable, .pwrite, .pready, .paddr, .pwdata,
        .fail_count, .pending
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Result sink: random stalls, plus one long hold-off on request.
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            gap = no_gaps ? 0 : $urandom_range(0, 5);
            if (hold_sink) begin
                gap = 500;
                hold_sink = 1'b0;
            end
            if (gap > 0) begin
                i_out_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    task automatic send(input longint v, input bit last);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_sample_value <= VW'(v);
        i_is_last <= last;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Lets the block drain before the threshold may change.
    task automatic go_idle();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [mopv_pkg::APB_AW-1:0] addr, input longint val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= 32'(val);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == ADDR_THRESHOLD)
            thr_now = val;
    endtask

    function automatic longint pick_value(input bit force_keep);
        longint lo;
        lo = force_keep ? thr_now + 1 : VMIN;
        case ($urandom_range(0, 3))
            0: return lo + longint'($urandom_range(0, 32'(VMAX - lo)));
            1: return longint'($signed($urandom()));
            default: begin
                lo = thr_now + longint'($urandom_range(0, 200)) - 100;
                if (force_keep && lo <= thr_now)
                    lo = thr_now + 1;
                return (lo > VMAX) ? VMAX : (lo < VMIN) ? VMIN : lo;
            end
        endcase
    endfunction

    initial begin
        longint thr_plan[5] = '{0, -1000, VMIN, 64'sd123456, VMAX};
        int items;
        int len;
        bit fill;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Threshold at reset value zero.
        send(0, 1);
        send(7, 1);
        send(3, 0); send(9, 1);
        send(-5, 0); send(4, 0); send(1, 0); send(10, 1);
        send(VMAX, 0); send(VMAX - 1, 1);
        send(1, 0); send(2, 1);
        send(VMIN, 0); send(1, 0); send(0, 0); send(-1, 0); send(3, 1);
        go_idle();
        apb_write(ADDR_THRESHOLD, VMIN);
        apb_write(ADDR_UNMAPPED, 64'sd55);
        send(VMIN, 0); send(VMIN + 1, 0); send(VMAX, 0); send(-3, 1);
        go_idle();
        apb_write(ADDR_THRESHOLD, -10);
        send(-11, 0); send(-10, 0); send(-9, 0); send(-7, 1);
        send(-3, 0); send(-2, 1);

        for (int p = 0; p < 5; p++) begin
            go_idle();
            apb_write(ADDR_THRESHOLD, thr_plan[p]);
            no_gaps = (p == 2);
            if (p == 1)
                hold_sink = 1'b1;
            items = 0;
            while (items < ((p == 4) ? 60 : 290)) begin
                fill = (p != 4) && ($urandom_range(0, 29) == 0);
                len = fill ? 256 + $urandom_range(1, 6) : $urandom_range(1, 12);
                for (int k = 0; k < len; k++)
                    send(pick_value(fill || $urandom_range(0, 3) != 0), k == len - 1);
                items += len;
            end
        end

        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: median_of_positive_values_top.f
+incdir+sv
sv/mopv_pkg.sv
sv/mopv_ctrl.sv
sv/mopv_datapath.sv
sv/median_of_positive_values_top.sv
sv/mopv_checker.sv
tb/median_checker.sv
tb/median_of_positive_values_top_test.sv
